>>> rtl/core/osi_pkg.sv
// Package for the ordered set intersection unit: set capacity, opcodes,
// payload types and the request/response structs between top and set store.
// Depends on nothing.
package osi_pkg;

	localparam int CAPACITY = 64;
	localparam int VALUE_W  = 32;
	localparam int OP_W     = 2;

	typedef logic [OP_W-1:0]           op_t;
	typedef logic signed [VALUE_W-1:0] value_t;
	typedef logic [CAPACITY-1:0]       entry_vec_t;

	localparam op_t OP_CLEAR = 2'd0;
	localparam op_t OP_LOAD  = 2'd1;
	localparam op_t OP_PROBE = 2'd2;

	localparam logic STATUS_MATCH = 1'b0;
	localparam logic STATUS_FULL  = 1'b1;

	// One decoded request presented to the set store for a single cycle.
	typedef struct packed {
		logic   clear;
		logic   load;
		logic   probe;
		value_t value;
	} cam_req_t;

	// Lookup outcome for the request presented in the same cycle.
	typedef struct packed {
		logic hit;
		logic full;
	} cam_rsp_t;

endpackage

>>> rtl/core/osi_cam.sv
// Set store of the ordered set intersection unit: a row of value/valid
// cells with parallel compare, lowest-free-slot insert and erase on probe hit.
// Depends on osi_pkg.
module osi_cam (
	input  logic              clk,
	input  logic              arst_n,
	input  osi_pkg::cam_req_t req,
	output osi_pkg::cam_rsp_t rsp
);
	import osi_pkg::*;

	value_t     entry_values_q [CAPACITY];
	entry_vec_t entry_valid_q;
	entry_vec_t match_vec;
	entry_vec_t free_vec;
	entry_vec_t free_first;
	logic       hit;
	logic       full;
	logic       do_insert;

	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			match_vec[i] = entry_valid_q[i] && (entry_values_q[i] == req.value);
		end
	end

	// Isolate the lowest free entry.
	assign free_vec   = ~entry_valid_q;
	assign free_first = free_vec & (~free_vec + entry_vec_t'(1));
	assign hit        = |match_vec;
	assign full       = &entry_valid_q;
	assign do_insert  = req.load && !hit && !full;

	assign rsp.hit  = hit;
	assign rsp.full = full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_valid_q <= '0;
		end else if (req.clear) begin
			entry_valid_q <= '0;
		end else if (req.probe) begin
			entry_valid_q <= entry_valid_q & ~match_vec;
		end else if (do_insert) begin
			entry_valid_q <= entry_valid_q | free_first;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < CAPACITY; i++) begin
			if (do_insert && free_first[i]) begin
				entry_values_q[i] <= req.value;
			end
		end
	end

	// The set never holds a value twice, so at most one cell matches.
	a_single_match: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(match_vec))
		else $error("more than one set entry matches");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		req.clear |=> (entry_valid_q == '0))
		else $error("set not empty after clear");

	a_full_drop_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		(req.load && full && !req.clear && !req.probe) |=> $stable(entry_valid_q))
		else $error("load into a full set changed the set");

endmodule

>>> rtl/core/ordered_set_intersection_unit.sv
// Top level of the ordered set intersection unit: request register, set
// store and result register.
// Depends on osi_pkg and osi_cam.
//
//  channel   ports                          handshake
//  --------  -----------------------------  -----------------------------------
//  request   opcode, item_value             taken at an edge with start & !busy
//  result    result_value, status           one cycle, marked by done
//
// From acceptance to result a request passes the request register, where it
// is evaluated against the set store (one parallel compare over all entries),
// and then the result register.
// A new request is taken every cycle; busy stays low. Results cannot be
// stalled, so each is marked by done for exactly one cycle.
// Reset empties the set and drops any request in flight; no clearing pass.
module ordered_set_intersection_unit (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  osi_pkg::op_t    opcode,
	input  osi_pkg::value_t item_value,
	output logic            done,
	output osi_pkg::value_t result_value,
	output logic            status
);
	import osi_pkg::*;

	logic     valid_s1;
	op_t      op_s1;
	value_t   value_s1;
	cam_req_t cam_req;
	cam_rsp_t cam_rsp;
	logic     emit;
	logic     done_q;
	value_t   result_value_q;
	logic     status_q;

	// The set store evaluates each request combinationally and cannot stall, so never hold off.
	assign busy = 1'b0;

	// Hold the accepted request for its evaluation cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			op_s1    <= opcode;
			value_s1 <= item_value;
		end
	end

	// Decode the opcode; the unused code does nothing.
	always_comb begin
		cam_req       = '0;
		cam_req.value = value_s1;
		if (valid_s1) begin
			unique case (op_s1)
				OP_CLEAR: cam_req.clear = 1'b1;
				OP_LOAD:  cam_req.load  = 1'b1;
				OP_PROBE: cam_req.probe = 1'b1;
				default:  cam_req.clear = 1'b0;
			endcase
		end
	end

	osi_cam u_cam (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (cam_req),
		.rsp    (cam_rsp)
	);

	// Emit on a probe hit, or on a new value that finds the set full.
	assign emit = (cam_req.probe && cam_rsp.hit)
		|| (cam_req.load && !cam_rsp.hit && cam_rsp.full);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			result_value_q <= value_s1;
			status_q       <= cam_req.load ? STATUS_FULL : STATUS_MATCH;
		end
	end

	assign done         = done_q;
	assign result_value = result_value_q;
	assign status       = status_q;

	a_done_from_request: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(valid_s1))
		else $error("result without a request in flight");

	a_full_from_load: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == STATUS_FULL) |-> $past(op_s1 == OP_LOAD))
		else $error("full status from a request that was not a load");

	a_match_from_probe: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == STATUS_MATCH) |-> $past(op_s1 == OP_PROBE))
		else $error("match result from a request that was not a probe");

endmodule

>>> tb/sv/ordered_set_intersection_unit_test.sv
// Self-checking testbench for ordered_set_intersection_unit: drives clear, load and
// probe requests with random gaps and checks every result against a set model.
// Depends on osi_pkg and the RTL of the unit.
module ordered_set_intersection_unit_test;
	import osi_pkg::*;

	localparam op_t OP_UNUSED      = 2'd3;
	localparam int  REQUEST_TARGET = 1650;
	localparam int  DRAIN_CYCLES   = 8;
	localparam int  WATCHDOG_LIMIT = 2000;

	typedef struct {
		value_t value;
		logic   status;
	} set_result_t;

	// Model of the fixed-capacity set. It updates on every accepted request
	// and queues the result that the request must produce, if any.
	class intersection_scoreboard;
		value_t      entry_value [CAPACITY];
		bit          entry_live  [CAPACITY];
		set_result_t pending_results [$];
		int unsigned mismatches;

		function void note_request(op_t op, value_t v);
			int hit_slot;
			int free_slot;
			hit_slot  = -1;
			free_slot = -1;
			// Lowest matching live entry and lowest free entry, as the
			// parallel compare in the store would find them.
			for (int i = 0; i < CAPACITY; i++) begin
				if (entry_live[i] && entry_value[i] == v && hit_slot < 0)
					hit_slot = i;
				if (!entry_live[i] && free_slot < 0)
					free_slot = i;
			end
			case (op)
			OP_CLEAR: begin
				foreach (entry_live[i])
					entry_live[i] = 1'b0;
			end
			OP_LOAD: begin
				// Duplicate loads change nothing, even into a full set.
				if (hit_slot < 0) begin
					if (free_slot < 0) begin
						pending_results.push_back('{v, STATUS_FULL});
					end else begin
						entry_value[free_slot] = v;
						entry_live[free_slot]  = 1'b1;
					end
				end
			end
			OP_PROBE: begin
				// A hit consumes the entry so an equal later probe misses.
				if (hit_slot >= 0) begin
					entry_live[hit_slot] = 1'b0;
					pending_results.push_back('{v, STATUS_MATCH});
				end
			end
			default: ;
			endcase
		endfunction

		function void check_result(value_t v, logic st);
			set_result_t want;
			if (pending_results.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result: expected none, actual value %h status %b",
					$time, v, st);
				return;
			end
			want = pending_results.pop_front();
			if (v !== want.value) begin
				mismatches++;
				$display("%0t: result_value mismatch: expected %h, actual %h",
					$time, want.value, v);
			end
			if (st !== want.status) begin
				mismatches++;
				$display("%0t: status mismatch: expected %b, actual %b",
					$time, want.status, st);
			end
		endfunction
	endclass

	logic   clk        = 1'b0;
	logic   arst_n     = 1'b0;
	logic   start      = 1'b0;
	op_t    opcode     = OP_CLEAR;
	value_t item_value = '0;
	logic   busy;
	logic   done;
	value_t result_value;
	logic   status;

	intersection_scoreboard set_model = new();
	int                     requests_sent;
	int                     stall_cycles;

	ordered_set_intersection_unit u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.opcode       (opcode),
		.item_value   (item_value),
		.done         (done),
		.result_value (result_value),
		.status       (status)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Sample both channels at the rising edge. Results pass the request and
	// result registers after their request is noted, so the check always finds
	// its expectation already queued. The watchdog ends the run when neither
	// channel moves for too long, which also catches results that never arrive.
	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				set_model.check_result(result_value, status);
			if (start && !busy)
				set_model.note_request(opcode, item_value);
			if (done || (start && !busy)) begin
				stall_cycles = 0;
			end else begin
				stall_cycles++;
				if (stall_cycles >= WATCHDOG_LIMIT) begin
					$display("ordered_set_intersection_unit_test NOT OK");
					$finish;
				end
			end
		end
	end

	// Bias toward the sign extremes and a narrow band around zero so that
	// duplicates and repeat probes come up often.
	function automatic value_t random_value();
		case ($urandom_range(9))
		0:       return value_t'(32'h8000_0000);
		1:       return value_t'(32'h7FFF_FFFF);
		2, 3:    return value_t'($urandom_range(16)) - value_t'(8);
		default: return value_t'($urandom);
		endcase
	endfunction

	// Enter and leave at a falling edge. Hold start high from one request to
	// the next unless an idle gap is drawn; drive junk on the payload while idle.
	// No idling while the request count sits in the quiet stretch.
	task automatic send_request(op_t op, value_t v);
		while ((requests_sent < 700 || requests_sent >= 1000) && $urandom_range(99) < 24) begin
			start      <= 1'b0;
			opcode     <= op_t'($urandom);
			item_value <= value_t'($urandom);
			@(negedge clk);
		end
		start      <= 1'b1;
		opcode     <= op;
		item_value <= v;
		do @(posedge clk); while (busy);
		@(negedge clk);
		if (op != OP_UNUSED)
			requests_sent++;
	endtask

	// One well-formed pass: clear, fill (sometimes past capacity), then probe
	// with a mix of loaded values, repeats and strangers. Now and then skip
	// the clear or slip in an ignored opcode, a stray probe or a stray load.
	task automatic run_set_session();
		value_t loaded [$];
		value_t probed [$];
		value_t v;
		int     n_loads;
		int     n_probes;
		if ($urandom_range(19) != 0)
			send_request(OP_CLEAR, value_t'($urandom));
		n_loads = ($urandom_range(3) == 0) ? $urandom_range(64, 90) : $urandom_range(0, 40);
		repeat (n_loads) begin
			if (loaded.size() > 0 && $urandom_range(4) == 0)
				v = loaded[$urandom_range(loaded.size() - 1)];
			else
				v = random_value();
			loaded.push_back(v);
			send_request(OP_LOAD, v);
			if ($urandom_range(19) == 0)
				send_request($urandom_range(1) ? OP_UNUSED : OP_PROBE, random_value());
		end
		n_probes = $urandom_range(loaded.size() + 8);
		repeat (n_probes) begin
			case ($urandom_range(9))
			0, 1: v = random_value();
			2, 3: v = (probed.size() > 0) ? probed[$urandom_range(probed.size() - 1)]
				: random_value();
			default: v = (loaded.size() > 0) ? loaded[$urandom_range(loaded.size() - 1)]
				: random_value();
			endcase
			probed.push_back(v);
			send_request(OP_PROBE, v);
			if ($urandom_range(19) == 0)
				send_request($urandom_range(1) ? OP_UNUSED : OP_LOAD, random_value());
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: extremes, duplicate load, hit then repeat miss, plain
		// miss, ignored opcode, clear followed by a probe of a cleared value.
		send_request(OP_CLEAR, value_t'(32'hFFFF_FFFF));
		send_request(OP_LOAD,  value_t'(32'h8000_0000));
		send_request(OP_LOAD,  value_t'(32'h7FFF_FFFF));
		send_request(OP_LOAD,  value_t'(32'h0000_0000));
		send_request(OP_LOAD,  value_t'(32'hFFFF_FFFF));
		send_request(OP_LOAD,  value_t'(32'hFFFF_FFFF));
		send_request(OP_PROBE, value_t'(32'h7FFF_FFFF));
		send_request(OP_PROBE, value_t'(32'h7FFF_FFFF));
		send_request(OP_PROBE, value_t'(32'h5555_AAAA));
		send_request(OP_UNUSED, value_t'(32'h0000_0000));
		send_request(OP_PROBE, value_t'(32'h0000_0000));
		send_request(OP_PROBE, value_t'(32'h8000_0000));
		send_request(OP_PROBE, value_t'(32'hFFFF_FFFF));
		send_request(OP_LOAD,  value_t'(32'hAAAA_5555));
		send_request(OP_CLEAR, value_t'(32'hAAAA_5555));
		send_request(OP_PROBE, value_t'(32'hAAAA_5555));

		while (requests_sent < REQUEST_TARGET)
			run_set_session();
		start <= 1'b0;

		// Drain: wait out every queued result, then leave room for strays.
		while (set_model.pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (set_model.mismatches == 0)
			$display("ordered_set_intersection_unit_test OK");
		else
			$display("ordered_set_intersection_unit_test NOT OK");
		$finish;
	end

endmodule
